// ===== sv/fspe_pkg.sv =====
// Shared types and constants for the frustum side-plane extractor.
package fspe_pkg;

   typedef struct packed {
      logic              kind;
      logic [1:0]        row;
      logic [1:0]        col;
      logic signed [31:0] element;
      logic              compute_now;
   } req_type;

   typedef struct packed {
      logic [1:0]         plane;
      logic [1:0]         coefficient;
      logic signed [31:0] coeff_value;
      logic               degenerate;
      logic               final_res;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_ABS,
      S_SCALE,
      S_SQ,
      S_SQRT,
      S_DSTART,
      S_DIV,
      S_EMIT
   } state_type;

   // control carried alongside a product through the multiply pipeline
   typedef struct packed {
      logic       valid;
      logic [1:0] comp;
      logic       sub;
   } mac_ctl_type;

   localparam int unsigned ACC_W      = 64;
   localparam int unsigned NORM_LIMIT = 30;
   localparam logic [5:0]  MAC_END    = 6'd32;
   localparam logic [5:0]  SQ_ISSUES  = 6'd3;
   localparam logic [5:0]  SQ_END     = 6'd4;
   localparam logic [1:0]  PLANE_LAST = 2'd3;
   localparam logic [1:0]  COEF_LAST  = 2'd3;
   localparam logic [1:0]  COL_W      = 2'd3;

endpackage

// ===== sv/fspe_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
module fspe_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] product
);
   import fspe_pkg::*;

   logic signed [63:0] product_ff;
   logic signed [63:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== sv/fspe_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module fspe_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import fspe_pkg::*;

   logic [63:0] n_ff, n_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ===== sv/fspe_div.sv =====
// Restoring divider giving floor(mag * 2^FRAC_BITS / divisor), saturating at 2^31.
module fspe_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] mag,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quot
);
   import fspe_pkg::*;

   localparam int unsigned DVD_W = 64 + FRAC_BITS;
   localparam int unsigned HI_W  = DVD_W - 31;

   logic [DVD_W-1:0] dvd;
   logic [HI_W-1:0]  dvd_hi;
   logic             sat;
   logic [31:0]      rem_ff, rem_in;
   logic [30:0]      low_ff, low_in;
   logic [30:0]      q_ff, q_in;
   logic             sat_ff, sat_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [32:0]      trial;

   assign dvd    = {mag, {FRAC_BITS{1'b0}}};
   assign dvd_hi = dvd[DVD_W-1:31];
   // quotient reaches 2^31 exactly when bits 31 and up already hold the divisor
   assign sat    = dvd_hi >= HI_W'(divisor);

   always_comb begin
      trial   = {rem_ff, low_ff[30]};
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = sat ? 32'd0 : dvd_hi[31:0];
         low_in  = dvd[30:0];
         q_in    = '0;
         sat_in  = sat;
         cnt_in  = 5'd30;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = 32'(trial - {1'b0, divisor});
            q_in   = {q_ff[29:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[29:0], 1'b0};
         end
         low_in = {low_ff[29:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = sat_ff ? 32'h8000_0000 : {1'b0, q_ff};

endmodule

// ===== sv/frustum_side_plane_extract.sv =====
// Frustum side-plane extractor: matrix stores, sequencer and normalisation datapath.
// Loads: one element transfer per cycle; ready only while idle, so one item at a time.
// Compute per plane: multiply, drain, abs, scale shifts, square, root, then per coefficient
//   a divide start, divide and emit; a degenerate plane goes from square straight to emit.
// Multiply and square share one multiplier; root and divide are bit-serial. Synchronous
//   reset clears the sequencer and output valid; the stores are not cleared.
module frustum_side_plane_extract #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fspe_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fspe_pkg::rsp_type rsp
);
   import fspe_pkg::*;

   state_type state_ff, state_in;

   logic [31:0] view_mem [16];
   logic [31:0] proj_mem [16];
   logic signed [31:0] view_q_ff, proj_q_ff;

   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  plane_ff, plane_in;
   logic [1:0]  coef_ff, coef_in;
   mac_ctl_type p1_ff, p1_in, p2_ff;
   logic signed [ACC_W-1:0] acc_ff [4];
   logic [63:0] mag_ff [4];
   logic        neg_ff [4];
   logic [63:0] len2_ff;
   logic        degen_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_fire, start_job, mac_issue, sqrt_start, div_start, emit_fire;
   logic        clear_acc;
   logic        over;
   logic [1:0]  mac_comp, mac_k, mac_j;
   logic        mac_half, mac_sub, plane_add;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] product;
   logic signed [ACC_W-1:0] term;
   logic        sqrt_done, div_done;
   logic [31:0] root, quot;
   logic signed [31:0] value;

   fspe_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   fspe_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (len2_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   fspe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .mag     (mag_ff[coef_ff]),
      .divisor (root),
      .done    (div_done),
      .quot    (quot)
   );

   // step order: component, then column 3 / other column, then inner index
   assign mac_comp  = cnt_ff[4:3];
   assign mac_half  = cnt_ff[2];
   assign mac_k     = cnt_ff[1:0];
   assign mac_j     = mac_half ? {1'b0, plane_ff[1]} : COL_W;
   assign plane_add = ~(plane_ff[0] ^ plane_ff[1]);
   assign mac_sub   = mac_half ? plane_add : 1'b1;
   assign over      = (|mag_ff[0][63:NORM_LIMIT]) | (|mag_ff[1][63:NORM_LIMIT])
                    | (|mag_ff[2][63:NORM_LIMIT]);
   assign term      = product >>> FRAC_BITS;

   always_comb begin
      if (state_ff == S_SQ) begin
         mul_a = mag_ff[cnt_ff[1:0]][31:0];
         mul_b = mag_ff[cnt_ff[1:0]][31:0];
      end else begin
         mul_a = view_q_ff;
         mul_b = proj_q_ff;
      end
   end

   always_comb begin
      if (degen_ff) begin
         value = '0;
      end else if (neg_ff[coef_ff]) begin
         value = 32'(32'd0 - quot);
      end else if (quot[31]) begin
         value = 32'h7FFF_FFFF;
      end else begin
         value = quot;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid && req.compute_now) state_in = S_MAC;
         S_MAC:    if (cnt_ff == MAC_END) state_in = S_DRAIN;
         S_DRAIN:  if (!p1_ff.valid && !p2_ff.valid) state_in = S_ABS;
         S_ABS:    state_in = S_SCALE;
         S_SCALE:  if (!over) state_in = S_SQ;
         S_SQ: begin
            if (cnt_ff == SQ_END) state_in = (len2_ff == 64'd0) ? S_EMIT : S_SQRT;
         end
         S_SQRT:   if (sqrt_done) state_in = S_DSTART;
         S_DSTART: state_in = S_DIV;
         S_DIV:    if (div_done) state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               priority if (coef_ff != COEF_LAST) state_in = degen_ff ? S_EMIT : S_DSTART;
               else if (plane_ff == PLANE_LAST) state_in = S_IDLE;
               else state_in = S_MAC;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      mac_issue  = (state_ff == S_MAC) && !cnt_ff[5];
      sqrt_start = (state_ff == S_SQ) && (cnt_ff == SQ_END) && (len2_ff != 64'd0);
      div_start  = (state_ff == S_DSTART);
      emit_fire  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_fire  = req_valid && req_ready;
   assign start_job = req_fire && req.compute_now;
   assign clear_acc = start_job || (emit_fire && coef_ff == COEF_LAST);

   // datapath next values
   always_comb begin
      cnt_in   = cnt_ff;
      plane_in = plane_ff;
      coef_in  = coef_ff;
      p1_in    = '0;
      if (mac_issue) begin
         p1_in = '{valid: 1'b1, comp: mac_comp, sub: mac_sub};
      end
      if (start_job) begin
         cnt_in   = '0;
         plane_in = '0;
         coef_in  = '0;
      end else if (mac_issue) begin
         cnt_in = cnt_ff + 6'd1;
      end else if (state_ff == S_SCALE) begin
         cnt_in = '0;
      end else if (state_ff == S_SQ && cnt_ff != SQ_END) begin
         cnt_in = cnt_ff + 6'd1;
      end else if (emit_fire) begin
         coef_in = coef_ff + 2'd1;
         if (coef_ff == COEF_LAST) begin
            plane_in = plane_ff + 2'd1;
            cnt_in   = '0;
         end
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.plane       = plane_ff;
         rsp_in.coefficient = coef_ff;
         rsp_in.coeff_value = value;
         rsp_in.degenerate  = degen_ff;
         rsp_in.final_res   = (plane_ff == PLANE_LAST) && (coef_ff == COEF_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         p1_ff        <= '0;
         p2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff        <= p1_in;
         p2_ff        <= p1_ff;
      end
      cnt_ff   <= cnt_in;
      plane_ff <= plane_in;
      coef_ff  <= coef_in;
      rsp_ff   <= rsp_in;
   end

   // matrix stores
   always_ff @(posedge clock) begin
      if (req_fire && req.kind) begin
         proj_mem[{req.row, req.col}] <= req.element;
      end
      if (req_fire && !req.kind) begin
         view_mem[{req.row, req.col}] <= req.element;
      end
      view_q_ff <= view_mem[{mac_comp, mac_k}];
      proj_q_ff <= proj_mem[{mac_k, mac_j}];
   end

   // accumulation, magnitudes, scaling and squared length
   always_ff @(posedge clock) begin
      if (clear_acc) begin
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (p2_ff.valid) begin
         acc_ff[p2_ff.comp] <= p2_ff.sub ? acc_ff[p2_ff.comp] - term
                                         : acc_ff[p2_ff.comp] + term;
      end
      if (state_ff == S_ABS) begin
         for (int i = 0; i < 4; i++) begin
            neg_ff[i] <= acc_ff[i][ACC_W-1];
            mag_ff[i] <= acc_ff[i][ACC_W-1] ? 64'(-acc_ff[i]) : 64'(acc_ff[i]);
         end
      end else if (state_ff == S_SCALE && over) begin
         for (int i = 0; i < 4; i++) begin
            mag_ff[i] <= mag_ff[i] >> 1;
         end
      end
      if (state_ff == S_SCALE) begin
         len2_ff <= '0;
      end else if (state_ff == S_SQ && cnt_ff != 6'd0 && cnt_ff <= SQ_ISSUES) begin
         len2_ff <= len2_ff + 64'(product);
      end
      if (state_ff == S_SQ && cnt_ff == SQ_END) begin
         degen_ff <= (len2_ff == 64'd0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_norm_scaled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQ) |-> !over)
      else $error("normal not scaled below limit");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.degenerate) |-> (rsp_ff.coeff_value == 32'sd0))
      else $error("degenerate plane with non-zero coefficient");

   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_SQRT))
      else $error("root finished outside its state");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divide finished outside its state");

   a_mac_order: assert property (@(posedge clock) disable iff (reset)
      p2_ff.valid |-> (state_ff == S_MAC || state_ff == S_DRAIN))
      else $error("product accumulated outside multiply phase");

endmodule

// ===== tb/tb_frustum_side_plane_extract.sv =====
// Self-checking testbench for the frustum side-plane extractor.
`timescale 1ns / 100ps

module tb_frustum_side_plane_extract;
   import fspe_pkg::*;

   localparam int FRAC = 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   frustum_side_plane_extract #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   req_type     pending_q[$];
   rsp_type     coeff_q[$];
   logic [31:0] view_m[16];
   logic [31:0] proj_m[16];
   int          errors = 0;
   int          send_idle = 12;
   int          recv_idle = 57;
   int          hold_cycles = 0;
   bit          stim_done = 1'b0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint fshift(input longint p);
      return p >>> FRAC;
   endfunction

   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] scale_coeff(input longint unsigned mag, input bit neg,
                                               input longint unsigned r);
      longint unsigned qi, rem, q;
      qi = mag / r;
      rem = mag % r;
      if (qi >= (64'd1 << (31 - FRAC))) q = 64'd1 << 31;
      else q = (qi << FRAC) + ((rem << FRAC) / r);
      if (neg) return 32'd0 - q[31:0];
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   // store the element; on a compute request queue the sixteen plane coefficients
   task automatic predict_planes(input req_type it);
      longint          m[4][4];
      longint          s, v;
      longint unsigned mag[4], mx, len2, r;
      bit              neg[4], degen, add;
      int              other, sh;
      rsp_type         e;
      if (it.kind) proj_m[{it.row, it.col}] = it.element;
      else view_m[{it.row, it.col}] = it.element;
      if (!it.compute_now) return;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            s = 0;
            for (int k = 0; k < 4; k++)
               s += fshift(longint'($signed(view_m[i*4+k])) *
                           longint'($signed(proj_m[k*4+j])));
            m[i][j] = s;
         end
      for (int p = 0; p < 4; p++) begin
         other = (p < 2) ? 0 : 1;
         add = (p == 0 || p == 3);
         mx = 0;
         for (int c = 0; c < 4; c++) begin
            v = add ? -(m[c][3] + m[c][other]) : -(m[c][3] - m[c][other]);
            neg[c] = v < 0;
            mag[c] = neg[c] ? -v : v;
            if (c < 3 && mag[c] > mx) mx = mag[c];
         end
         sh = 0;
         while ((mx >> sh) >= (64'd1 << 30)) sh++;
         for (int c = 0; c < 4; c++) mag[c] >>= sh;
         len2 = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
         degen = (len2 == 0);
         r = degen ? 1 : root64(len2);
         for (int c = 0; c < 4; c++) begin
            e.plane = 2'(p);
            e.coefficient = 2'(c);
            e.coeff_value = degen ? '0 : scale_coeff(mag[c], neg[c] && mag[c] != 0, r);
            e.degenerate = degen;
            e.final_res = (p == 3 && c == 3);
            coeff_q.push_back(e);
         end
      end
   endtask

   function automatic logic [31:0] rand_elem(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   // full load of both matrices, random order, compute on the last transfer
   task automatic queue_frame(input int mode);
      req_type it;
      int      ord[32];
      for (int i = 0; i < 32; i++) ord[i] = i;
      ord.shuffle();
      for (int i = 0; i < 32; i++) begin
         it.kind = ord[i][4];
         {it.row, it.col} = ord[i][3:0];
         it.element = rand_elem(mode);
         it.compute_now = (i == 31);
         pending_q.push_back(it);
      end
   endtask

   task automatic queue_item(input bit kind, input int idx, input logic [31:0] val,
                             input bit go);
      req_type it;
      it.kind = kind;
      {it.row, it.col} = idx[3:0];
      it.element = val;
      it.compute_now = go;
      pending_q.push_back(it);
   endtask

   task automatic wait_drain;
      while (pending_q.size() != 0 || req_valid || coeff_q.size() != 0) @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_planes(req);
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (coeff_q.size() == 0) begin
               report($sformatf("unexpected transfer plane %0d coef %0d",
                                rsp.plane, rsp.coefficient));
            end else begin
               e = coeff_q.pop_front();
               if (rsp.plane !== e.plane) report("plane");
               if (rsp.coefficient !== e.coefficient) report("coefficient");
               if (rsp.coeff_value !== e.coeff_value)
                  report($sformatf("value p%0d c%0d got %h want %h", e.plane,
                                   e.coefficient, rsp.coeff_value, e.coeff_value));
               if (rsp.degenerate !== e.degenerate) report("degenerate");
               if (rsp.final_res !== e.final_res) report("final_res");
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   initial begin
      for (int i = 0; i < 16; i++) begin
         view_m[i] = '0;
         proj_m[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // identity view, simple projection
      for (int i = 0; i < 16; i++) queue_item(1'b0, i, (i % 5 == 0) ? 32'h1_0000 : 0, 1'b0);
      for (int i = 0; i < 16; i++)
         queue_item(1'b1, i, (i % 5 == 0) ? 32'h1_0000 : 0, i == 15);
      // zero projection gives degenerate planes
      for (int i = 0; i < 16; i++) queue_item(1'b1, i, 32'h0, i == 15);
      // extremes, then long receiver hold while items keep coming
      queue_item(1'b1, 0, 32'h7FFF_FFFF, 1'b0);
      queue_item(1'b1, 15, 32'h8000_0000, 1'b0);
      queue_item(1'b0, 0, 32'h8000_0000, 1'b1);
      queue_item(1'b1, 5, 32'hFFFF_FFFF, 1'b1);
      hold_cycles = 3000;
      wait_drain();

      for (int f = 0; f < 6; f++) begin
         if (f == 2) begin
            wait_drain();
            send_idle = 57;
            recv_idle = 12;
         end
         if (f == 4) begin
            wait_drain();
            send_idle = 0;
            recv_idle = 0;
         end
         queue_frame(f % 4);
         // a single update with compute after each frame to exercise partial reloads
         queue_item($urandom_range(0, 1), $urandom_range(0, 15), rand_elem(f % 4), 1'b1);
      end
      wait_drain();
      repeat (900) @(posedge clock);
      if (errors == 0 && coeff_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
